// File: rtl/sfade_pkg.sv
// Shared types and constants for the staggered three-channel fade engine.
// Used by the divider and the top level; depends on nothing else.
package sfade_pkg;

	// Input kinds carried in the slave-side tuser field.
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_FADE_IN  = 2'd1;
	localparam logic [1:0] OP_FADE_OUT = 2'd2;

	// Fade mode reported in each result.
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_IN   = 2'd1;
	localparam logic [1:0] MODE_OUT  = 2'd2;

	// Register indexes on the configuration port (byte address is four times this).
	localparam logic [2:0] REG_DELAY_FIRST   = 3'd0;
	localparam logic [2:0] REG_DELAY_SECOND  = 3'd1;
	localparam logic [2:0] REG_DELAY_THIRD   = 3'd2;
	localparam logic [2:0] REG_FADE_LENGTH   = 3'd3;
	localparam logic [2:0] REG_MAX_STEP      = 3'd4;
	localparam logic [2:0] REG_UPDATE_PERIOD = 3'd5;

	localparam logic [7:0] DUTY_FULL = 8'd255;

	// Divider geometry: every quotient this block needs is below 256, so the
	// numerator stays below 256 times the divisor and eight steps suffice.
	localparam int NUM_W     = 24;
	localparam int DEN_W     = 16;
	localparam int QUOT_W    = 8;
	localparam int DIV_STEPS = QUOT_W;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DECODE = 8'b0000_0010,
		ST_CURVE  = 8'b0000_0100,
		ST_APPLY  = 8'b0000_1000,
		ST_CHAN   = 8'b0001_0000,
		ST_RAMP   = 8'b0010_0000,
		ST_FINISH = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

endpackage

// File: rtl/sfade_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on sfade_pkg for its request and response structs.
module sfade_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sfade_pkg::div_req_t req,
	output sfade_pkg::div_rsp_t rsp
);
	import sfade_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic [DEN_W-1:0]  rem_q;
	logic [QUOT_W-1:0] low_q;
	logic [DEN_W-1:0]  den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0]    trial;
	logic              ge;
	logic [DEN_W:0]    diff;

	// The partial remainder is always below the divisor, so the trial value
	// needs one extra bit and the difference fits back into the remainder.
	assign trial = {rem_q, low_q[QUOT_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NUM_W-1:QUOT_W];
			low_q <= req.num[QUOT_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q <= {low_q[QUOT_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = low_q;

endmodule

// File: rtl/staggered_three_channel_fade_top.sv
// Top level of the staggered three-channel fade engine: sequencer, registers,
// configuration port and output register. Depends on sfade_pkg and sfade_div.
//
// Usage: each input transfer carries a kind in s_tuser (tick, start fade in,
// start fade out) and the millisecond time and step in s_tdata. Every input
// transfer yields exactly one result transfer with the three duties, the
// duty write flag in m_tuser, the mode and the finished flag.
// The block takes one item at a time: s_tready is high only while the
// sequencer is idle. All divisions go through one shared divider, which
// holds the sequencer while it works. A fade start passes decode, a curve
// division unless the step needs none, apply and output; a tick that updates
// the duties passes decode, each channel with a ramp division for each
// ramping channel, finish and output; any other item passes decode and
// output. The next item can be taken in the cycle after a result is registered.
// The result waits in an output register; while the receiver stalls, the
// next finished result waits in the sequencer, which takes no new item.
// Reset, asynchronous and active low, loads the default register values,
// puts the engine in idle with the finished flag set and empties the
// output register. Configuration is written over the APB-style port at
// byte address four times the register index; pready is always high.
module staggered_three_channel_fade_top #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [31:0] time_ms, [39:32] step
	input  logic [1:0]  s_tuser,  // [1:0] opcode
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] duty_one, [15:8] duty_two, [23:16] duty_three,
	                              // [25:24] mode, [26] finished, [31:27] zero
	output logic        m_tuser   // [0] duty_write
);
	import sfade_pkg::*;

	// Configuration registers.
	logic [15:0] delay_q [3];
	logic [15:0] fade_length_q;
	logic [7:0]  max_step_q;
	logic [9:0]  update_period_q;

	// Engine state.
	state_t               state_q;
	logic [1:0]           mode_q;
	logic                 done_q;
	logic [TIME_BITS-1:0] start_time_q;
	logic [TIME_BITS-1:0] last_update_q;
	logic [7:0]           from_q;
	logic [7:0]           to_q;

	// Current item and work registers.
	logic [1:0]           op_q;
	logic [TIME_BITS-1:0] now_q;
	logic [7:0]           step_q;
	logic [7:0]           curve_q;
	logic [1:0]           ch_q;
	logic                 settled_q;
	logic [7:0]           res_duty_q [3];
	logic                 res_wr_q;

	// Output register.
	logic        out_valid_q;
	logic [7:0]  out_duty_q [3];
	logic        out_wr_q;
	logic [1:0]  out_mode_q;
	logic        out_fin_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                 cfg_wr;
	logic                 in_xfer;
	logic                 fade_op;
	logic                 curve_div;
	logic                 tick_go;
	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] since_update;
	logic [1:0]           dl_idx;
	logic [15:0]          dl;
	logic                 in_delay;
	logic [TIME_BITS-1:0] ce;
	logic                 at_target;
	logic                 down;
	logic [7:0]           diff;
	logic [15:0]          ss;
	logic [15:0]          mm;
	logic [NUM_W-1:0]     curve_num;
	logic [NUM_W-1:0]     ramp_num;
	logic [NUM_W-1:0]     ramp_prod;
	logic                 last_ch;
	logic                 out_free;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q[0]      <= 16'd0;
			delay_q[1]      <= 16'd200;
			delay_q[2]      <= 16'd400;
			fade_length_q   <= 16'd1000;
			max_step_q      <= 8'd10;
			update_period_q <= 10'd10;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_DELAY_FIRST:   delay_q[0]      <= pwdata[15:0];
				REG_DELAY_SECOND:  delay_q[1]      <= pwdata[15:0];
				REG_DELAY_THIRD:   delay_q[2]      <= pwdata[15:0];
				REG_FADE_LENGTH:   fade_length_q   <= pwdata[15:0];
				REG_MAX_STEP:      max_step_q      <= pwdata[7:0];
				REG_UPDATE_PERIOD: update_period_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_DELAY_FIRST:   prdata = {16'd0, delay_q[0]};
			REG_DELAY_SECOND:  prdata = {16'd0, delay_q[1]};
			REG_DELAY_THIRD:   prdata = {16'd0, delay_q[2]};
			REG_FADE_LENGTH:   prdata = {16'd0, fade_length_q};
			REG_MAX_STEP:      prdata = {24'd0, max_step_q};
			REG_UPDATE_PERIOD: prdata = {22'd0, update_period_q};
			default:           prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------- datapath terms
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	assign fade_op      = (op_q == OP_FADE_IN) || (op_q == OP_FADE_OUT);
	assign curve_div    = (step_q != 8'd0) && (step_q < max_step_q);
	assign since_update = now_q - last_update_q;
	assign tick_go      = (op_q == OP_TICK) && (mode_q != MODE_IDLE) && !done_q &&
	                      (since_update >= TIME_BITS'(update_period_q));

	assign elapsed   = now_q - start_time_q;
	// Fade-out walks the delays in reverse channel order.
	assign dl_idx    = (mode_q == MODE_OUT) ? 2'd2 - ch_q : ch_q;
	assign dl        = delay_q[dl_idx];
	assign in_delay  = elapsed < TIME_BITS'(dl);
	assign ce        = elapsed - TIME_BITS'(dl);
	assign at_target = ce >= TIME_BITS'(fade_length_q);
	assign down      = to_q < from_q;
	assign diff      = down ? from_q - to_q : to_q - from_q;
	assign last_ch   = (ch_q == 2'd2);

	assign ss        = {8'd0, step_q} * {8'd0, step_q};
	assign mm        = {8'd0, max_step_q} * {8'd0, max_step_q};
	assign curve_num = {ss, 8'd0} - {8'd0, ss};

	// Falling ramps round the step up, toward the lower value, so the numerator
	// gets the divisor minus one added before dividing.
	assign ramp_prod = {16'd0, diff} * {8'd0, ce[15:0]};
	assign ramp_num  = ramp_prod + (down ? {8'd0, fade_length_q - 16'd1} : '0);

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = ramp_num;
		div_req.den   = fade_length_q;
		if (state_q == ST_DECODE) begin
			div_req.start = fade_op && curve_div;
			div_req.num   = curve_num;
			div_req.den   = mm;
		end else if (state_q == ST_CHAN) begin
			div_req.start = !in_delay && !at_target;
		end
	end

	sfade_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_free = !out_valid_q || m_tready;

	// The output register is loaded from the sequencer and emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= MODE_IDLE;
			done_q        <= 1'b1;
			start_time_q  <= '0;
			last_update_q <= '0;
			from_q        <= 8'd0;
			to_q          <= 8'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (fade_op) begin
						state_q <= curve_div ? ST_CURVE : ST_APPLY;
					end else if (tick_go) begin
						last_update_q <= now_q;
						state_q       <= ST_CHAN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_CURVE: begin
					if (div_rsp.done) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					mode_q        <= (op_q == OP_FADE_IN) ? MODE_IN : MODE_OUT;
					start_time_q  <= now_q;
					last_update_q <= now_q;
					done_q        <= 1'b0;
					if (op_q == OP_FADE_IN) begin
						from_q <= 8'd0;
						to_q   <= curve_q;
					end else begin
						from_q <= curve_q;
						to_q   <= 8'd0;
					end
					state_q <= ST_OUT;
				end
				ST_CHAN: begin
					if (div_req.start) begin
						state_q <= ST_RAMP;
					end else if (last_ch) begin
						state_q <= ST_FINISH;
					end
				end
				ST_RAMP: begin
					if (div_rsp.done) begin
						state_q <= last_ch ? ST_FINISH : ST_CHAN;
					end
				end
				ST_FINISH: begin
					if (settled_q) begin
						done_q <= 1'b1;
						mode_q <= MODE_IDLE;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Work and result registers need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					op_q   <= s_tuser;
					now_q  <= s_tdata[TIME_BITS-1:0];
					step_q <= s_tdata[39:32];
				end
			end
			ST_DECODE: begin
				res_duty_q[0] <= 8'd0;
				res_duty_q[1] <= 8'd0;
				res_duty_q[2] <= 8'd0;
				res_wr_q      <= tick_go;
				ch_q          <= 2'd0;
				settled_q     <= 1'b1;
				curve_q       <= (step_q == 8'd0) ? 8'd0 : DUTY_FULL;
			end
			ST_CURVE: begin
				if (div_rsp.done) begin
					curve_q <= div_rsp.quot;
				end
			end
			ST_APPLY: begin
				res_wr_q <= (op_q == OP_FADE_IN);
			end
			ST_CHAN: begin
				if (in_delay) begin
					res_duty_q[ch_q] <= from_q;
					settled_q        <= 1'b0;
				end else if (at_target) begin
					res_duty_q[ch_q] <= to_q;
				end
				if (!div_req.start && !last_ch) begin
					ch_q <= ch_q + 2'd1;
				end
			end
			ST_RAMP: begin
				if (div_rsp.done) begin
					res_duty_q[ch_q] <= down ? from_q - div_rsp.quot : from_q + div_rsp.quot;
					settled_q        <= 1'b0;
					if (!last_ch) begin
						ch_q <= ch_q + 2'd1;
					end
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_duty_q[0] <= res_duty_q[0];
					out_duty_q[1] <= res_duty_q[1];
					out_duty_q[2] <= res_duty_q[2];
					out_wr_q      <= res_wr_q;
					out_mode_q    <= mode_q;
					out_fin_q     <= done_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_fin_q, out_mode_q, out_duty_q[2], out_duty_q[1], out_duty_q[0]};
	assign m_tuser  = out_wr_q;

`ifndef SYNTH
	// A finished engine is always back in idle mode.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (mode_q == MODE_IDLE))
		else $error("finished flag set while a fade is running");

	// The shared divider is never restarted while it is still working.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// An item passes the decode state before its result appears.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result presented in the cycle after acceptance");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking bench for the staggered three-channel fade engine: a directed table, then
// randomized fade sequences under several register settings and flow-control patterns.
// Depends on sfade_pkg and staggered_three_channel_fade_top; results are checked in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sfade_pkg::*;

	// Input kind that the engine ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 60;
	localparam int QUIET_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 45;
	localparam int PHASES = 8;

	typedef struct packed {
		logic [7:0] duty_one;
		logic [7:0] duty_two;
		logic [7:0] duty_three;
		logic       duty_write;
		logic [1:0] mode;
		logic       finished;
	} fade_result_t;

	typedef struct {
		logic         is_reg;
		logic [2:0]   reg_idx;
		logic [31:0]  value;  // time for an item, register value for a write
		logic [1:0]   op;
		logic [7:0]   step;
		logic         typed;
		fade_result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // [31:0] time_ms, [39:32] step
	logic [1:0]  s_tuser = '0;  // [1:0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // [7:0] duty_one, [15:8] duty_two, [23:16] duty_three,
	                            // [25:24] mode, [26] finished
	logic        m_tuser;       // [0] duty_write

	staggered_three_channel_fade_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6;
		clk = 1'b1;
		#6;
		clk = 1'b0;
	end

	// Register copy and engine state as the checker sees them.
	logic [15:0] cfg_delay [3] = '{16'd0, 16'd200, 16'd400};
	logic [15:0] cfg_fade_len = 16'd1000;
	logic [7:0]  cfg_max_step = 8'd10;
	logic [9:0]  cfg_period = 10'd10;

	logic [1:0]  fade_mode = MODE_IDLE;
	logic [31:0] fade_start = '0;
	logic [31:0] last_update = '0;
	logic [7:0]  from_duty = '0;
	logic [7:0]  to_duty = '0;
	logic        fade_done = 1'b1;

	fade_result_t pending_results [$];
	int          err_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          quiet_cycles = 0;
	dir_row_t    dir_rows [$];

	function automatic logic [7:0] step_to_duty(input logic [7:0] st);
		logic [31:0] sq;
		logic [31:0] msq;
		if (st == 8'd0)
			return 8'd0;
		if (st >= cfg_max_step)
			return DUTY_FULL;
		sq = 32'(st) * 32'(st) * 32'd255;
		msq = 32'(cfg_max_step) * 32'(cfg_max_step);
		return 8'(sq / msq);
	endfunction

	// Linear blend truncated toward the lower value, whichever way the ramp runs.
	function automatic logic [7:0] ramp_duty(input logic [7:0] a, input logic [7:0] b,
		input logic [31:0] c, input logic [15:0] len);
		logic [63:0] d;
		if (b >= a) begin
			d = 64'(b - a) * 64'(c) / 64'(len);
			return a + d[7:0];
		end
		d = (64'(a - b) * 64'(c) + 64'(len) - 64'd1) / 64'(len);
		return a - d[7:0];
	endfunction

	function automatic fade_result_t next_fade_result(input logic [1:0] op,
		input logic [31:0] now, input logic [7:0] st);
		fade_result_t r;
		logic [31:0]  elapsed;
		logic [31:0]  ce;
		logic [15:0]  dl;
		logic [7:0]   duty [3];
		logic         settled;
		r = '0;
		duty = '{8'd0, 8'd0, 8'd0};
		if (op == OP_FADE_IN || op == OP_FADE_OUT) begin
			fade_mode = (op == OP_FADE_IN) ? MODE_IN : MODE_OUT;
			fade_start = now;
			last_update = now;
			fade_done = 1'b0;
			if (op == OP_FADE_IN) begin
				from_duty = 8'd0;
				to_duty = step_to_duty(st);
				r.duty_write = 1'b1;
			end else begin
				from_duty = step_to_duty(st);
				to_duty = 8'd0;
			end
		end else if (op == OP_TICK && fade_mode != MODE_IDLE && !fade_done &&
				(now - last_update) >= 32'(cfg_period)) begin
			elapsed = now - fade_start;
			last_update = now;
			r.duty_write = 1'b1;
			settled = 1'b1;
			for (int ch = 0; ch < 3; ch++) begin
				// Fading out walks the delays from the last channel back to the first.
				dl = cfg_delay[(fade_mode == MODE_OUT) ? 2 - ch : ch];
				if (elapsed < 32'(dl)) begin
					duty[ch] = from_duty;
					settled = 1'b0;
				end else begin
					ce = elapsed - 32'(dl);
					if (ce >= 32'(cfg_fade_len)) begin
						duty[ch] = to_duty;
					end else begin
						duty[ch] = ramp_duty(from_duty, to_duty, ce, cfg_fade_len);
						settled = 1'b0;
					end
				end
			end
			if (settled) begin
				fade_done = 1'b1;
				fade_mode = MODE_IDLE;
			end
		end
		r.duty_one = duty[0];
		r.duty_two = duty[1];
		r.duty_three = duty[2];
		r.mode = fade_mode;
		r.finished = fade_done;
		return r;
	endfunction

	function automatic dir_row_t dir_item(input logic [1:0] op, input logic [31:0] now,
		input logic [7:0] st);
		dir_row_t row;
		row = '{is_reg: 1'b0, reg_idx: '0, value: now, op: op, step: st, typed: 1'b0,
			want: '0};
		return row;
	endfunction

	function automatic dir_row_t dir_check(input logic [1:0] op, input logic [31:0] now,
		input logic [7:0] st, input logic [7:0] d1, input logic [7:0] d2,
		input logic [7:0] d3, input logic wr, input logic [1:0] md, input logic fin);
		dir_row_t row;
		row = dir_item(op, now, st);
		row.typed = 1'b1;
		row.want = '{d1, d2, d3, wr, md, fin};
		return row;
	endfunction

	function automatic dir_row_t dir_reg(input logic [2:0] idx, input logic [31:0] val);
		dir_row_t row;
		row = '{is_reg: 1'b1, reg_idx: idx, value: val, op: OP_TICK, step: '0, typed: 1'b0,
			want: '0};
		return row;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	task automatic bus_access(input logic [2:0] idx, input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes a register with junk above its width, then reads it back.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] mask;
		logic [31:0] rd;
		case (idx)
			REG_MAX_STEP:      mask = 32'h0000_00ff;
			REG_UPDATE_PERIOD: mask = 32'h0000_03ff;
			default:           mask = 32'h0000_ffff;
		endcase
		bus_access(idx, 1'b1, ($urandom & ~mask) | (val & mask), rd);
		case (idx)
			REG_DELAY_FIRST:   cfg_delay[0] = 16'(val & mask);
			REG_DELAY_SECOND:  cfg_delay[1] = 16'(val & mask);
			REG_DELAY_THIRD:   cfg_delay[2] = 16'(val & mask);
			REG_FADE_LENGTH:   cfg_fade_len = 16'(val & mask);
			REG_MAX_STEP:      cfg_max_step = 8'(val & mask);
			REG_UPDATE_PERIOD: cfg_period = 10'(val & mask);
			default: ;
		endcase
		@(posedge clk);
		bus_access(idx, 1'b0, 32'd0, rd);
		check_field($sformatf("register %0d readback", idx), val & mask, rd);
		@(posedge clk);
	endtask

	// Offers one item, holding it until the engine takes it; valid stays high afterwards
	// so that a back-to-back item needs no second assignment in the same step.
	task automatic send_item(input logic [1:0] op, input logic [31:0] now,
		input logic [7:0] st, input logic typed, input fade_result_t want);
		fade_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {st, now};
		s_tuser <= op;
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		r = next_fade_result(op, now, st);
		pending_results.push_back(typed ? want : r);
	endtask

	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		fade_result_t got;
		fade_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.duty_one = m_tdata[7:0];
			got.duty_two = m_tdata[15:8];
			got.duty_three = m_tdata[23:16];
			got.mode = m_tdata[25:24];
			got.finished = m_tdata[26];
			got.duty_write = m_tuser;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected");
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("duty_one", 32'(want.duty_one), 32'(got.duty_one));
				check_field("duty_two", 32'(want.duty_two), 32'(got.duty_two));
				check_field("duty_three", 32'(want.duty_three), 32'(got.duty_three));
				check_field("duty_write", 32'(want.duty_write), 32'(got.duty_write));
				check_field("mode", 32'(want.mode), 32'(got.mode));
				check_field("finished", 32'(want.finished), 32'(got.finished));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		dir_row_t    row;
		logic [31:0] now;
		logic [31:0] span;
		logic [31:0] inc;
		logic [15:0] dmax;
		int          items;
		int          nticks;
		int          sel;

		// Directed part, run with the reset register values until the writes near the end.
		dir_rows.push_back(dir_check(OP_TICK, 32'd0, 8'd0, 0, 0, 0, 0, MODE_IDLE, 1));
		dir_rows.push_back(dir_check(OP_UNUSED, 32'd77, 8'd255, 0, 0, 0, 0, MODE_IDLE, 1));
		dir_rows.push_back(dir_check(OP_FADE_IN, 32'd1000, 8'd255, 0, 0, 0, 1, MODE_IN, 0));
		dir_rows.push_back(dir_check(OP_TICK, 32'd1009, 8'd0, 0, 0, 0, 0, MODE_IN, 0));
		dir_rows.push_back(dir_item(OP_TICK, 32'd1010, 8'd0));
		dir_rows.push_back(dir_item(OP_TICK, 32'd1700, 8'd0));
		dir_rows.push_back(dir_check(OP_TICK, 32'd2400, 8'd0, 255, 255, 255, 1, MODE_IDLE, 1));
		dir_rows.push_back(dir_check(OP_TICK, 32'd2500, 8'd0, 0, 0, 0, 0, MODE_IDLE, 1));
		dir_rows.push_back(dir_check(OP_FADE_OUT, 32'hffff_ff00, 8'd0, 0, 0, 0, 0, MODE_OUT,
			0));
		// The tick time wraps past zero.
		dir_rows.push_back(dir_item(OP_TICK, 32'h0000_0100, 8'hff));
		dir_rows.push_back(dir_item(OP_TICK, 32'hffff_ff09, 8'h00));
		dir_rows.push_back(dir_check(OP_FADE_OUT, 32'd5000, 8'd5, 0, 0, 0, 0, MODE_OUT, 0));
		dir_rows.push_back(dir_item(OP_TICK, 32'd5300, 8'd0));
		dir_rows.push_back(dir_item(OP_TICK, 32'd5900, 8'd0));
		dir_rows.push_back(dir_check(OP_TICK, 32'd6400, 8'd0, 0, 0, 0, 1, MODE_IDLE, 1));
		dir_rows.push_back(dir_check(OP_FADE_IN, 32'd7000, 8'd1, 0, 0, 0, 1, MODE_IN, 0));
		dir_rows.push_back(dir_item(OP_TICK, 32'd7600, 8'd0));
		// A new start while a fade is still running.
		dir_rows.push_back(dir_check(OP_FADE_IN, 32'd8000, 8'd9, 0, 0, 0, 1, MODE_IN, 0));
		dir_rows.push_back(dir_item(OP_TICK, 32'd8500, 8'd0));
		dir_rows.push_back(dir_item(OP_TICK, 32'hffff_ffff, 8'd0));
		// Zero ramp length, zero maximum step and no update period.
		dir_rows.push_back(dir_reg(REG_FADE_LENGTH, 32'd0));
		dir_rows.push_back(dir_reg(REG_MAX_STEP, 32'd0));
		dir_rows.push_back(dir_reg(REG_UPDATE_PERIOD, 32'd0));
		dir_rows.push_back(dir_check(OP_FADE_IN, 32'd100, 8'd1, 0, 0, 0, 1, MODE_IN, 0));
		dir_rows.push_back(dir_check(OP_TICK, 32'd100, 8'd0, 255, 0, 0, 1, MODE_IN, 0));
		dir_rows.push_back(dir_check(OP_TICK, 32'd400, 8'd0, 255, 255, 0, 1, MODE_IN, 0));
		dir_rows.push_back(dir_check(OP_TICK, 32'd500, 8'd0, 255, 255, 255, 1, MODE_IDLE, 1));
		dir_rows.push_back(dir_check(OP_FADE_OUT, 32'd600, 8'd0, 0, 0, 0, 0, MODE_OUT, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		recv_stall_pct = 33;
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_reg) begin
				settle_idle();
				write_reg(row.reg_idx, row.value);
			end else begin
				send_item(row.op, row.value, row.step, row.typed, row.want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			settle_idle();
			case (phase)
				0: begin
					write_reg(REG_DELAY_FIRST, 0);
					write_reg(REG_DELAY_SECOND, 3);
					write_reg(REG_DELAY_THIRD, 7);
					write_reg(REG_FADE_LENGTH, 20);
					write_reg(REG_MAX_STEP, 10);
					write_reg(REG_UPDATE_PERIOD, 1);
				end
				1: begin
					write_reg(REG_DELAY_FIRST, 65535);
					write_reg(REG_DELAY_SECOND, 65535);
					write_reg(REG_DELAY_THIRD, 65535);
					write_reg(REG_FADE_LENGTH, 65535);
					write_reg(REG_MAX_STEP, 255);
					write_reg(REG_UPDATE_PERIOD, 1023);
				end
				2: begin
					write_reg(REG_DELAY_FIRST, 0);
					write_reg(REG_DELAY_SECOND, 0);
					write_reg(REG_DELAY_THIRD, 0);
					write_reg(REG_FADE_LENGTH, 0);
					write_reg(REG_MAX_STEP, 0);
					write_reg(REG_UPDATE_PERIOD, 0);
				end
				3: begin
					write_reg(REG_DELAY_FIRST, 5);
					write_reg(REG_DELAY_SECOND, 0);
					write_reg(REG_DELAY_THIRD, 9);
					write_reg(REG_FADE_LENGTH, 1);
					write_reg(REG_MAX_STEP, 1);
					write_reg(REG_UPDATE_PERIOD, 0);
				end
				7: begin
					write_reg(REG_DELAY_FIRST, $urandom);
					write_reg(REG_DELAY_SECOND, $urandom);
					write_reg(REG_DELAY_THIRD, $urandom);
					write_reg(REG_FADE_LENGTH, $urandom);
					write_reg(REG_MAX_STEP, $urandom);
					write_reg(REG_UPDATE_PERIOD, $urandom);
				end
				default: begin
					write_reg(REG_DELAY_FIRST, $urandom_range(0, 40));
					write_reg(REG_DELAY_SECOND, $urandom_range(0, 40));
					write_reg(REG_DELAY_THIRD, $urandom_range(0, 40));
					write_reg(REG_FADE_LENGTH, $urandom_range(1, 60));
					write_reg(REG_MAX_STEP, $urandom_range(1, 255));
					write_reg(REG_UPDATE_PERIOD, $urandom_range(0, 8));
				end
			endcase
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase

			dmax = cfg_delay[0];
			if (cfg_delay[1] > dmax)
				dmax = cfg_delay[1];
			if (cfg_delay[2] > dmax)
				dmax = cfg_delay[2];
			span = 32'(dmax) + 32'(cfg_fade_len) + 32'd1;

			items = 0;
			while (items < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) < 8) begin
					// A fade start followed by ticks whose time never goes back, until it is done
					// or the sequence is cut short.
					now = $urandom;
					send_item($urandom_range(0, 1) ? OP_FADE_IN : OP_FADE_OUT, now,
						8'($urandom_range(0, 255)), 1'b0, '0);
					items++;
					nticks = $urandom_range(3, 20);
					for (int k = 0; k < nticks && !fade_done; k++) begin
						sel = $urandom_range(0, 9);
						case (sel)
							0: inc = 32'd0;
							1: inc = (cfg_period > 0) ? 32'(cfg_period) - 32'd1 : 32'd0;
							2: inc = 32'(cfg_period);
							3: inc = span + 32'(cfg_period);
							default: inc = $urandom_range(32'(cfg_period),
								32'(cfg_period) + span / 5 + 32'd1);
						endcase
						now = now + inc;
						send_item(OP_TICK, now, 8'($urandom_range(0, 255)), 1'b0, '0);
						items++;
					end
				end else begin
					send_item(2'($urandom_range(0, 3)), $urandom, 8'($urandom_range(0, 255)),
						1'b0, '0);
					items++;
				end
			end
		end

		settle_idle();
		if (err_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
